[design/port_block_allocator_by_mac_unit_defines.svh]
// Assertion helpers for the port block allocator.
`ifndef PORT_BLOCK_ALLOCATOR_BY_MAC_UNIT_DEFINES_SVH
`define PORT_BLOCK_ALLOCATOR_BY_MAC_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PBAM_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PBAM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    `PBAM_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

[design/pbam_pkg.sv]
package pbam_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int PORT_W  = 16;
    localparam int MAC_W   = 48;
    localparam int CMD_W   = 2;
    localparam int RIDX_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [RIDX_W-1:0] {
        REG_START_PORT = 2'd0,
        REG_END_PORT   = 2'd1,
        REG_BLOCK_SIZE = 2'd2
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [PORT_W-1:0] start_port;
        logic [PORT_W-1:0] end_port;
        logic [PORT_W-1:0] block_size;
    } cfg_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [MAC_W-1:0] wr_data;
    } ram_req_t;

endpackage

[design/pbam_owner_ram.sv]
module pbam_owner_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/pbam_scan.sv]
module pbam_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pbam_pkg::cfg_t                 cfg,
    input  logic                           cfg_clear,
    input  logic                           start,
    input  logic [pbam_pkg::CMD_W-1:0]     command,
    input  logic [pbam_pkg::MAC_W-1:0]     mac_address,
    output logic                           busy,
    output pbam_pkg::ram_req_t             ram_req,
    input  logic [pbam_pkg::MAC_W-1:0]     ram_rd_data,
    output logic                           done,
    output logic                           ok,
    output logic [pbam_pkg::PORT_W-1:0]    low_port,
    output logic [pbam_pkg::PORT_W-1:0]    high_port
);
    import pbam_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [PORT_W:0]     acc_reg;
    logic                p_vld_reg;
    logic [IDX_W-1:0]    p_k_reg;
    logic [PORT_W:0]     p_acc_reg;
    logic [ENTRIES-1:0]  in_use_reg;
    logic                done_reg;
    logic                ok_reg;
    logic [PORT_W-1:0]   low_reg;
    logic [PORT_W-1:0]   high_reg;

    logic                cmd_known;
    logic                issue;
    logic                hit_raw;
    logic                hit;
    logic                finish;
    logic                give_ports;
    logic [PORT_W:0]     high_sum;
    logic [PORT_W-1:0]   high_sat;

    // Walk control: issue one owner read per cycle while the block exists.
    always_comb
    begin
        cmd_known = (cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_QUERY)
                 || (cmd_reg == CMD_RELEASE);
        issue = (state_reg == ST_SCAN) && cmd_known
             && (cfg.block_size != '0)
             && (k_reg < CNT_W'(ENTRIES))
             && (acc_reg < {1'b0, cfg.end_port});
        case (cmd_reg)
            CMD_ALLOC:   hit_raw = !in_use_reg[p_k_reg];
            CMD_QUERY,
            CMD_RELEASE: hit_raw = in_use_reg[p_k_reg] && (ram_rd_data == mac_reg);
            default:     hit_raw = 1'b0;
        endcase
        hit        = p_vld_reg && hit_raw;
        finish     = (state_reg == ST_SCAN) && (hit || !issue);
        give_ports = hit && ((cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_QUERY));
        high_sum   = p_acc_reg + {1'b0, cfg.block_size} - (PORT_W+1)'(1);
        high_sat   = high_sum[PORT_W] ? '1 : high_sum[PORT_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy            = (state_reg != ST_IDLE);
        ram_req.rd_en   = issue;
        ram_req.rd_addr = k_reg[IDX_W-1:0];
        ram_req.wr_en   = finish && hit && (cmd_reg == CMD_ALLOC);
        ram_req.wr_addr = p_k_reg;
        ram_req.wr_data = mac_reg;
        done            = done_reg;
        ok              = ok_reg;
        low_port        = low_reg;
        high_port       = high_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            p_vld_reg  <= 1'b0;
            in_use_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (state_reg == ST_IDLE)
            begin
                p_vld_reg <= 1'b0;
            end
            else
            begin
                p_vld_reg <= issue;
            end
            // Clear all marks on a write to a known register, else update the chosen block.
            if (cfg_clear)
            begin
                in_use_reg <= '0;
            end
            else if (finish && hit)
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    in_use_reg[p_k_reg] <= 1'b1;
                end
                else if (cmd_reg == CMD_RELEASE)
                begin
                    in_use_reg[p_k_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg <= command;
            mac_reg <= mac_address;
            k_reg   <= '0;
            acc_reg <= {1'b0, cfg.start_port};
        end
        else if (issue)
        begin
            k_reg   <= k_reg + CNT_W'(1);
            acc_reg <= acc_reg + {1'b0, cfg.block_size};
        end
        if (issue)
        begin
            p_k_reg   <= k_reg[IDX_W-1:0];
            p_acc_reg <= acc_reg;
        end
        if (finish)
        begin
            ok_reg   <= hit;
            low_reg  <= give_ports ? p_acc_reg[PORT_W-1:0] : '0;
            high_reg <= give_ports ? high_sat : '0;
        end
    end

endmodule

[design/port_block_allocator_by_mac_unit.sv]
// An accepted item walks the blocks in order, one owner read per block; the
// walk ends on a hit or after the last of at most ENTRIES blocks.
// Throughput: one item at a time, set by the one-entry-per-cycle walk through
// the owner RAM read port; busy drops in the cycle the result strobe shows.
// Reset clears the in-use marks, the walk state and the config registers to
// their defaults at once; results cannot be stalled, done lasts one cycle.
module port_block_allocator_by_mac_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [pbam_pkg::CMD_W-1:0]    command,
    input  logic [pbam_pkg::MAC_W-1:0]    mac_address,
    // result strobe
    output logic                          done,
    output logic                          ok,
    output logic [pbam_pkg::PORT_W-1:0]   low_port,
    output logic [pbam_pkg::PORT_W-1:0]   high_port,
    // register write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pbam_pkg::RIDX_W-1:0]   cfg_index,
    input  logic [pbam_pkg::PORT_W-1:0]   cfg_data
);
    import pbam_pkg::*;

    cfg_t             cfg_reg;
    logic             cfg_we;
    logic             cfg_clear;
    ram_req_t         ram_req;
    logic [MAC_W-1:0] ram_rd_data;

    // Take register writes only between items.
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Any write to a known register drops every in-use mark; an unknown index
    // is ignored entirely.
    always_comb
    begin
        case (cfg_index)
            REG_START_PORT,
            REG_END_PORT,
            REG_BLOCK_SIZE: cfg_clear = cfg_we;
            default:        cfg_clear = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_port <= '0;
            cfg_reg.end_port   <= '0;
            cfg_reg.block_size <= PORT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_PORT: cfg_reg.start_port <= cfg_data;
                REG_END_PORT:   cfg_reg.end_port   <= cfg_data;
                REG_BLOCK_SIZE: cfg_reg.block_size <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Walker: holds the in-use marks and steps block by block, comparing the
    // owner read back in the cycle after its address went out. The only write
    // to the owner RAM lands on the finishing edge, so no read of the same
    // item can see a stale entry and no forwarding is needed.
    pbam_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cfg_clear   (cfg_clear),
        .start       (start),
        .command     (command),
        .mac_address (mac_address),
        .busy        (busy),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .done        (done),
        .ok          (ok),
        .low_port    (low_port),
        .high_port   (high_port)
    );

    // Owner MAC store; every walked entry is read, but compared only if its mark says written.
    pbam_owner_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (MAC_W)
    ) u_owner_ram (
        .clk     (clk),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data)
    );

endmodule

[design/pbam_checker.sv]
`include "port_block_allocator_by_mac_unit_defines.svh"

module pbam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [15:0] low_port,
    input logic [15:0] high_port
);

    `PBAM_ASSERT_IMPLY(a_done_idle, done, !busy, "result shown while still busy")
    `PBAM_ASSERT_CLK(a_start_busy, (start && !busy) |=> busy, "accepted item did not go busy")
    `PBAM_ASSERT_IMPLY(a_miss_zero, done && !ok, (low_port == 16'd0) && (high_port == 16'd0),
        "failed item reports nonzero ports")
    `PBAM_ASSERT_IMPLY(a_port_order, done && ok, high_port >= low_port,
        "block high port below low port")

endmodule

bind port_block_allocator_by_mac_unit pbam_checker u_pbam_checker (.*);
